FILE: rtl/assert_macros.svh
// Assertion macros included by the RTL file that carries checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Same-cycle implication, checked outside reset.
`define ASSERT_IMPLY(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("assertion failed: cond implies prop");
// Next-cycle implication, checked outside reset.
`define ASSERT_NEXT(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("assertion failed: cond implies prop one cycle later");
`else
`define ASSERT_IMPLY(label, clk, rst_n, cond, prop)
`define ASSERT_NEXT(label, clk, rst_n, cond, prop)
`endif
`endif

FILE: rtl/udss_pkg.sv
// Types, constants and display decoding for the up/down seconds stopwatch.
package udss_pkg;

    localparam int unsigned TOP_W = 16;
    localparam logic [TOP_W-1:0] TOP_RESET = 16'd15624;
    localparam logic [5:0] SEC_LAST = 6'd59;

    localparam int unsigned BTN_START = 0;
    localparam int unsigned BTN_SWAP  = 1;
    localparam int unsigned BTN_CLEAR = 2;

    // One beat taken from the input stage into the counter.
    typedef struct packed {
        logic       advance;
        logic [2:0] buttons_n;
        logic       tick;
    } udss_step_t;

    // Counter status after the beat has been applied.
    typedef struct packed {
        logic [5:0] seconds;
        logic       running;
        logic       ascending;
    } udss_status_t;

    function automatic logic [6:0] seg_code(input logic [3:0] digit);
        logic [6:0] code;
        begin
            case (digit)
                4'd0:    code = 7'h3F;
                4'd1:    code = 7'h06;
                4'd2:    code = 7'h5B;
                4'd3:    code = 7'h4F;
                4'd4:    code = 7'h66;
                4'd5:    code = 7'h6D;
                4'd6:    code = 7'h7D;
                4'd7:    code = 7'h07;
                4'd8:    code = 7'h7F;
                4'd9:    code = 7'h67;
                default: code = 7'h3F;
            endcase
            return code;
        end
    endfunction

    // Splits 0..59 into tens and ones with a short compare chain.
    function automatic logic [13:0] seg_pair(input logic [5:0] secs);
        logic [2:0] tens;
        logic [5:0] base;
        logic [5:0] ones;
        begin
            if (secs >= 6'd50) tens = 3'd5;
            else if (secs >= 6'd40) tens = 3'd4;
            else if (secs >= 6'd30) tens = 3'd3;
            else if (secs >= 6'd20) tens = 3'd2;
            else if (secs >= 6'd10) tens = 3'd1;
            else tens = 3'd0;
            // Ten times the tens digit, as eight times plus two times.
            base = {tens, 3'b000} + {2'b00, tens, 1'b0};
            ones = secs - base;
            return {seg_code({1'b0, tens}), seg_code(ones[3:0])};
        end
    endfunction

endpackage

FILE: rtl/udss_core.sv
// Stopwatch state: button edges, sub-second count, seconds and flags.
module udss_core
    import udss_pkg::*;
#(
    parameter logic [TOP_W-1:0] TOP_INIT = TOP_RESET
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_wr_en,
    input  logic [TOP_W-1:0] cfg_wr_data,
    input  udss_step_t       step,
    output udss_status_t     status_next
);

    logic [TOP_W-1:0] top_reg;
    logic [TOP_W-1:0] sub_reg;
    logic [TOP_W-1:0] sub_next;
    logic [5:0]       sec_reg;
    logic [5:0]       sec_next;
    logic             run_reg;
    logic             run_next;
    logic             up_reg;
    logic             up_next;
    logic [2:0]       prev_reg;
    logic [2:0]       pressed;
    logic [2:0]       edges;
    logic [TOP_W-1:0] sub_btn;
    logic [5:0]       sec_btn;

    assign pressed = ~step.buttons_n;
    assign edges   = pressed & ~prev_reg;

    always_comb
    begin
        run_next = run_reg ^ edges[BTN_START];
        up_next  = up_reg ^ edges[BTN_SWAP];
        sub_btn  = edges[BTN_SWAP] ? (top_reg - sub_reg) : sub_reg;
        sec_btn  = sec_reg;
        if (edges[BTN_CLEAR])
        begin
            sub_btn = '0;
            sec_btn = '0;
        end
        sub_next = sub_btn;
        sec_next = sec_btn;
        if (step.tick && run_next)
        begin
            if (sub_btn == top_reg)
            begin
                sub_next = '0;
                if (up_next)
                    sec_next = (sec_btn >= SEC_LAST) ? 6'd0 : sec_btn + 6'd1;
                else
                    sec_next = (sec_btn == 6'd0 || sec_btn > SEC_LAST) ? SEC_LAST
                                                                       : sec_btn - 6'd1;
            end
            else
            begin
                sub_next = sub_btn + {{(TOP_W-1){1'b0}}, 1'b1};
            end
        end
    end

    assign status_next.seconds   = sec_next;
    assign status_next.running   = run_next;
    assign status_next.ascending = up_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            top_reg  <= TOP_INIT;
            sub_reg  <= '0;
            sec_reg  <= '0;
            run_reg  <= 1'b1;
            up_reg   <= 1'b1;
            prev_reg <= '0;
        end
        else
        begin
            if (cfg_wr_en)
                top_reg <= cfg_wr_data;
            if (step.advance)
            begin
                sub_reg  <= sub_next;
                sec_reg  <= sec_next;
                run_reg  <= run_next;
                up_reg   <= up_next;
                prev_reg <= pressed;
            end
        end
    end

endmodule

FILE: rtl/up_down_seconds_stopwatch.sv
// Up/down seconds stopwatch top level: input stage, counter and result register.
// A beat accepted into the input stage moves on into the result register when that stage advances.
// Throughput: one beat per cycle unless stalled; with both stages full, result_stall passes to item_stall.
// Reset (rst_n low, asynchronous) clears both stages, the counts and button history,
// sets running and ascending, and loads count_top with its default.
`include "assert_macros.svh"
module up_down_seconds_stopwatch
    import udss_pkg::*;
#(
    parameter logic [TOP_W-1:0] TOP_INIT = TOP_RESET
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_wr_en,
    input  logic [TOP_W-1:0] cfg_wr_data,
    input  logic             item_valid,
    output logic             item_stall,
    input  logic [2:0]       buttons_n,
    input  logic             tick,
    output logic             result_valid,
    input  logic             result_stall,
    output logic [5:0]       seconds,
    output logic [6:0]       seg_ones,
    output logic [6:0]       seg_tens,
    output logic             running,
    output logic             ascending
);

    logic         s1_valid_reg;
    logic         s1_valid_next;
    logic [2:0]   s1_buttons_reg;
    logic         s1_tick_reg;
    logic         s1_advance;
    logic         accept;
    logic         out_valid_reg;
    logic         out_valid_next;
    udss_step_t   step;
    udss_status_t status_next;
    udss_status_t status_reg;
    logic [13:0]  segs_reg;

    assign s1_advance = s1_valid_reg && (!out_valid_reg || !result_stall);
    assign item_stall = s1_valid_reg && !s1_advance;
    assign accept     = item_valid && !item_stall;

    assign s1_valid_next  = accept ? 1'b1 : (s1_advance ? 1'b0 : s1_valid_reg);
    assign out_valid_next = s1_advance ? 1'b1 : (result_stall ? out_valid_reg : 1'b0);

    assign step.advance   = s1_advance;
    assign step.buttons_n = s1_buttons_reg;
    assign step.tick      = s1_tick_reg;

    udss_core #(
        .TOP_INIT (TOP_INIT)
    ) u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .step        (step),
        .status_next (status_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_buttons_reg <= buttons_n;
            s1_tick_reg    <= tick;
        end
        if (s1_advance)
        begin
            status_reg <= status_next;
            segs_reg   <= seg_pair(status_next.seconds);
        end
    end

    assign result_valid = out_valid_reg;
    assign seconds      = status_reg.seconds;
    assign running      = status_reg.running;
    assign ascending    = status_reg.ascending;
    assign seg_tens     = segs_reg[13:7];
    assign seg_ones     = segs_reg[6:0];

    `ASSERT_IMPLY(a_sec_range, clk, rst_n, out_valid_reg, status_reg.seconds <= SEC_LAST)
    `ASSERT_IMPLY(a_stall_full, clk, rst_n, item_stall, s1_valid_reg && out_valid_reg)
    `ASSERT_NEXT(a_adv_result, clk, rst_n, s1_advance, out_valid_reg)

endmodule

FILE: tb/tb.sv
// Self-checking testbench for the up/down seconds stopwatch.
`timescale 1ns / 100ps

module tb
    import udss_pkg::*;
();

    typedef struct packed {
        logic [5:0] seconds;
        logic [6:0] seg_ones;
        logic [6:0] seg_tens;
        logic       running;
        logic       ascending;
    } display_t;

    typedef struct packed {
        logic [2:0] buttons_n;
        logic       tick;
        logic       known;
        display_t   want;
    } stim_row_t;

    localparam int RANDOM_PHASES = 7;
    localparam int BEATS_PER_PHASE = 250;
    localparam int DIRECTED_ROWS = 22;

    localparam logic [6:0] DIGIT_SEGS [10] = '{
        7'h3F, 7'h06, 7'h5B, 7'h4F, 7'h66, 7'h6D, 7'h7D, 7'h07, 7'h7F, 7'h67
    };

    // Rows run with count_top at its reset value. Typed results are marked known.
    localparam stim_row_t DIRECTED [DIRECTED_ROWS] = '{
        '{3'b111, 1'b0, 1'b1, '{6'd0, 7'h3F, 7'h3F, 1'b1, 1'b1}},
        '{3'b111, 1'b1, 1'b0, '0},
        '{3'b110, 1'b0, 1'b0, '0},
        '{3'b110, 1'b1, 1'b0, '0},
        '{3'b111, 1'b1, 1'b0, '0},
        '{3'b110, 1'b1, 1'b0, '0},
        '{3'b101, 1'b1, 1'b0, '0},
        '{3'b111, 1'b1, 1'b0, '0},
        '{3'b111, 1'b1, 1'b1, '{6'd59, 7'h67, 7'h6D, 1'b1, 1'b0}},
        '{3'b011, 1'b1, 1'b1, '{6'd0, 7'h3F, 7'h3F, 1'b1, 1'b0}},
        '{3'b111, 1'b0, 1'b0, '0},
        '{3'b000, 1'b1, 1'b1, '{6'd0, 7'h3F, 7'h3F, 1'b0, 1'b1}},
        '{3'b000, 1'b1, 1'b0, '0},
        '{3'b111, 1'b0, 1'b0, '0},
        '{3'b110, 1'b0, 1'b0, '0},
        '{3'b101, 1'b1, 1'b1, '{6'd59, 7'h67, 7'h6D, 1'b1, 1'b0}},
        '{3'b111, 1'b0, 1'b0, '0},
        '{3'b101, 1'b1, 1'b1, '{6'd0, 7'h3F, 7'h3F, 1'b1, 1'b1}},
        '{3'b111, 1'b1, 1'b0, '0},
        '{3'b001, 1'b1, 1'b0, '0},
        '{3'b100, 1'b0, 1'b0, '0},
        '{3'b111, 1'b1, 1'b0, '0}
    };

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             cfg_wr_en = 1'b0;
    logic [TOP_W-1:0] cfg_wr_data = '0;
    logic             item_valid = 1'b0;
    logic             item_stall;
    logic [2:0]       buttons_n = 3'b111;
    logic             tick = 1'b0;
    logic             result_valid;
    logic             result_stall = 1'b0;
    logic [5:0]       seconds;
    logic [6:0]       seg_ones;
    logic [6:0]       seg_tens;
    logic             running;
    logic             ascending;

    // Predicted state of the watch.
    logic [TOP_W-1:0] w_top = TOP_RESET;
    logic [TOP_W-1:0] w_sub = '0;
    logic [5:0]       w_secs = '0;
    logic             w_run = 1'b1;
    logic             w_up = 1'b1;
    logic [2:0]       w_prev = '0;

    display_t display_due [$];
    int       mismatches = 0;
    bit       calm = 1'b0;

    up_down_seconds_stopwatch dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .buttons_n    (buttons_n),
        .tick         (tick),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .seconds      (seconds),
        .seg_ones     (seg_ones),
        .seg_tens     (seg_tens),
        .running      (running),
        .ascending    (ascending)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic display_t advance_watch(input logic [2:0] bn, input logic tk);
        logic [2:0] pressed;
        logic [2:0] edges;
        display_t   d;
        pressed = ~bn;
        edges = pressed & ~w_prev;
        if (edges[BTN_START])
            w_run = !w_run;
        if (edges[BTN_SWAP])
        begin
            w_sub = w_top - w_sub;
            w_up = !w_up;
        end
        if (edges[BTN_CLEAR])
        begin
            w_sub = '0;
            w_secs = '0;
        end
        w_prev = pressed;
        if (tk && w_run)
        begin
            if (w_sub == w_top)
            begin
                w_sub = '0;
                if (w_up)
                    w_secs = (w_secs >= 6'd59) ? 6'd0 : w_secs + 6'd1;
                else
                    w_secs = (w_secs == 6'd0 || w_secs >= 6'd60) ? 6'd59 : w_secs - 6'd1;
            end
            else
                w_sub = w_sub + 1'b1;
        end
        d.seconds = w_secs;
        d.seg_ones = DIGIT_SEGS[w_secs % 10];
        d.seg_tens = DIGIT_SEGS[w_secs / 10];
        d.running = w_run;
        d.ascending = w_up;
        return d;
    endfunction

    // Offers one beat, with a random gap first, and returns at the edge that takes it.
    // The stall is looked at mid-cycle, where it already holds its value for the next edge.
    task automatic send_beat(input logic [2:0] bn, input logic tk, output display_t pred);
        while (!calm && $urandom_range(99) < 14)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item_valid <= 1'b1;
        buttons_n <= bn;
        tick <= tk;
        @(negedge clk);
        while (item_stall)
            @(negedge clk);
        @(posedge clk);
        pred = advance_watch(bn, tk);
    endtask

    task automatic drain_results;
        while (display_due.size() != 0)
            @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    task automatic write_top(input logic [TOP_W-1:0] value);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        w_top = value;
    endtask

    task automatic compare_field(input string name, input int want, input int got);
        if (want != got)
        begin
            $error("%s expected %0d got %0d", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk)
        result_stall <= !calm && ($urandom_range(99) < 14);

    always @(posedge clk)
    begin
        display_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            if (display_due.size() == 0)
            begin
                $error("result beat with nothing expected");
                mismatches++;
            end
            else
            begin
                want = display_due.pop_front();
                compare_field("seconds", want.seconds, seconds);
                compare_field("seg_ones", want.seg_ones, seg_ones);
                compare_field("seg_tens", want.seg_tens, seg_tens);
                compare_field("running", want.running, running);
                compare_field("ascending", want.ascending, ascending);
            end
        end
    end

    initial
    begin
        display_t   pred;
        logic [2:0] bn;
        logic       tk;
        logic [TOP_W-1:0] top;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (DIRECTED[i])
        begin
            send_beat(DIRECTED[i].buttons_n, DIRECTED[i].tick, pred);
            display_due.push_back(DIRECTED[i].known ? DIRECTED[i].want : pred);
        end

        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            item_valid <= 1'b0;
            drain_results();
            case (p)
                0: top = 16'd1;
                1: top = 16'hFFFF;
                2: top = 16'($urandom_range(1, 3));
                3: top = TOP_RESET;
                6: top = 16'($urandom_range(1, 65535));
                default: top = 16'($urandom_range(1, 12));
            endcase
            write_top(top);
            // The widest count runs with no gaps on either side.
            calm = (p == 1);
            for (int n = 0; n < BEATS_PER_PHASE; n++)
            begin
                bn = ($urandom_range(99) < 70) ? 3'b111 : 3'($urandom_range(0, 7));
                tk = $urandom_range(99) < 75;
                send_beat(bn, tk, pred);
                display_due.push_back(pred);
            end
        end

        item_valid <= 1'b0;
        calm = 1'b0;
        while (display_due.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (mismatches == 0)
            $display("up_down_seconds_stopwatch test passed");
        else
            $display("up_down_seconds_stopwatch test failed");
        $finish;
    end

    initial
    begin
        #1000000;
        $display("up_down_seconds_stopwatch test failed");
        $finish;
    end

endmodule
